// ===== design/rsme_pkg.sv =====
// Shared package of the register stack machine executor.
// It holds the sizes, the codes, the item types and the sequencer states.
// It has no dependencies.
package rsme_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int GENERAL_COUNT = 20;
   localparam int STACK_DEPTH   = 64;
   localparam int SPECIAL_COUNT = 5;
   localparam int INDEX_WIDTH   = 5;
   localparam int IMM_WIDTH     = 31;

   localparam int GEN_AW   = (GENERAL_COUNT > 1) ? $clog2(GENERAL_COUNT) : 1;
   localparam int SPEC_AW  = $clog2(SPECIAL_COUNT);
   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int DEPTH_W  = STACK_AW + 1;

   // Special register numbers that instructions write implicitly.
   localparam int SPEC_SUM  = 0;
   localparam int SPEC_QUO  = 1;
   localparam int SPEC_REM  = 2;
   localparam int SPEC_POP  = 3;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_PRINT = 3'd2,
      OP_MOV   = 3'd3,
      OP_ADD   = 3'd4,
      OP_SUB   = 3'd5,
      OP_MUL   = 3'd6,
      OP_DIV   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_IMM  = 2'd0,
      KIND_GEN  = 2'd1,
      KIND_SPEC = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_EMPTY   = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_DIVZERO = 3'd3,
      STAT_BADDEST = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_OPA,
      SEQ_OPB,
      SEQ_EXEC,
      SEQ_POPW,
      SEQ_MULW,
      SEQ_DIVW
   } state_type;

   // One operand after classification.
   typedef struct packed {
      kind_type                kind;
      logic [INDEX_WIDTH-1:0]  index;
      logic                    gen_ok;
      logic                    spec_ok;
      logic [DATA_WIDTH-1:0]   imm;
   } operand_type;

   // One classified instruction as it waits between front and back.
   typedef struct packed {
      op_type      op;
      operand_type a;
      operand_type b;
   } item_type;

   // One result item.
   typedef struct packed {
      status_type            status;
      logic                  print_valid;
      logic [DATA_WIDTH-1:0] print_value;
   } rsp_type;

endpackage

// ===== design/register_stack_machine_executor.sv =====
// Register stack machine executor. Instruction items enter through a two-entry
// queue and are carried out one at a time by a sequencer that reads the two
// operands one after the other from a single-read-port general register file.
// push, mov, add and sub end in the EXEC state; pop and print go on to POPW,
// mul to MULW, and div to DIVW to wait for the radix-2 divider's one quotient
// bit a cycle. An empty-stack pop or print and a divide by zero end in EXEC.
// Results wait in a two-entry queue, so the sequencer goes on while one waits.
// Depends on rsme_pkg, rsme_front and rsme_back.
module register_stack_machine_executor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [2:0]                           req_op,
   input  logic [1:0]                           req_a_kind,
   input  logic [rsme_pkg::INDEX_WIDTH-1:0]     req_a_index,
   input  logic [rsme_pkg::IMM_WIDTH-1:0]       req_a_imm,
   input  logic [1:0]                           req_b_kind,
   input  logic [rsme_pkg::INDEX_WIDTH-1:0]     req_b_index,
   input  logic [rsme_pkg::IMM_WIDTH-1:0]       req_b_imm,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [2:0]                           rsp_status,
   output logic                                 rsp_print_valid,
   output logic [rsme_pkg::DATA_WIDTH-1:0]      rsp_print_value
);

   logic                item_valid;
   logic                item_pop;
   rsme_pkg::item_type  item;
   rsme_pkg::rsp_type   rsp_data;

   rsme_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_op      (req_op),
      .req_a_kind  (req_a_kind),
      .req_a_index (req_a_index),
      .req_a_imm   (req_a_imm),
      .req_b_kind  (req_b_kind),
      .req_b_index (req_b_index),
      .req_b_imm   (req_b_imm),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   rsme_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   // Unpack the result item onto its ports.
   assign rsp_status      = rsp_data.status;
   assign rsp_print_valid = rsp_data.print_valid;
   assign rsp_print_value = rsp_data.print_value;

endmodule

// ===== design/rsme_front.sv =====
// Front part of the executor: accepts instruction items and classifies them.
// Classified items wait in a two-entry queue for the back part.
// Depends on rsme_pkg.
module rsme_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [2:0]                           req_op,
   input  logic [1:0]                           req_a_kind,
   input  logic [rsme_pkg::INDEX_WIDTH-1:0]     req_a_index,
   input  logic [rsme_pkg::IMM_WIDTH-1:0]       req_a_imm,
   input  logic [1:0]                           req_b_kind,
   input  logic [rsme_pkg::INDEX_WIDTH-1:0]     req_b_index,
   input  logic [rsme_pkg::IMM_WIDTH-1:0]       req_b_imm,
   output logic                                 item_valid,
   output rsme_pkg::item_type                   item,
   input  logic                                 item_pop
);

   rsme_pkg::item_type  class_item;
   rsme_pkg::item_type  queue_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   function automatic rsme_pkg::operand_type classify(
      input logic [1:0]                       kind,
      input logic [rsme_pkg::INDEX_WIDTH-1:0] index,
      input logic [rsme_pkg::IMM_WIDTH-1:0]   imm);
      rsme_pkg::operand_type o;
      case (rsme_pkg::kind_type'(kind))
         rsme_pkg::KIND_GEN:  o.kind = rsme_pkg::KIND_GEN;
         rsme_pkg::KIND_SPEC: o.kind = rsme_pkg::KIND_SPEC;
         default:             o.kind = rsme_pkg::KIND_IMM;
      endcase
      o.index   = index;
      o.gen_ok  = (32'(index) < rsme_pkg::GENERAL_COUNT);
      o.spec_ok = (32'(index) < rsme_pkg::SPECIAL_COUNT);
      o.imm     = rsme_pkg::DATA_WIDTH'(imm);
      return o;
   endfunction

   // Classify the incoming item: operand kinds and register ranges.
   always_comb begin
      class_item.op = rsme_pkg::op_type'(req_op);
      class_item.a  = classify(req_a_kind, req_a_index, req_a_imm);
      class_item.b  = classify(req_b_kind, req_b_index, req_b_imm);
   end

   // Queue control.
   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

// ===== design/rsme_divider.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Gives the truncated quotient and a remainder with the sign of the dividend.
// Depends on rsme_pkg.
module rsme_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rsme_pkg::DATA_WIDTH-1:0] dividend,
   input  logic [rsme_pkg::DATA_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [rsme_pkg::DATA_WIDTH-1:0] quotient,
   output logic [rsme_pkg::DATA_WIDTH-1:0] remainder
);

   localparam int W  = rsme_pkg::DATA_WIDTH;
   localparam int CW = $clog2(W);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [W:0]      rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    dsr_ff, dsr_in;
   logic            neg_q_ff, neg_q_in;
   logic            neg_r_ff, neg_r_in;
   logic [W:0]      rem_shift;
   logic [W:0]      trial;

   // One restoring step, or loading of the magnitudes at start.
   always_comb begin
      rem_shift = {rem_ff[W-1:0], quo_ff[W-1]};
      trial     = rem_shift - {1'b0, dsr_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         quo_in   = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dsr_in   = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         neg_q_in = dividend[W-1] ^ divisor[W-1];
         neg_r_in = dividend[W-1];
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial;
         end else begin
            rem_in = rem_shift;
         end
         quo_in = {quo_ff[W-2:0], ~trial[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // Apply the signs to the magnitudes.
   assign done      = done_ff;
   assign quotient  = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign remainder = neg_r_ff ? (~rem_ff[W-1:0] + 1'b1) : rem_ff[W-1:0];

endmodule

// ===== design/rsme_back.sv =====
// Back part of the executor: register files, value stack and the sequencer
// that carries out one instruction at a time, plus the two-entry result queue.
// Depends on rsme_pkg and rsme_divider.
module rsme_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  rsme_pkg::item_type              item,
   output logic                            item_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output rsme_pkg::rsp_type               rsp_data
);

   localparam int W = rsme_pkg::DATA_WIDTH;

   rsme_pkg::state_type  state_ff, state_in;
   rsme_pkg::item_type   ins_ff;
   logic [W-1:0]         va_ff, vb_ff, prod_ff;
   logic [rsme_pkg::DEPTH_W-1:0] depth_ff, depth_in;

   // Register files and stack.
   logic [W-1:0]  spec_ff [rsme_pkg::SPECIAL_COUNT];
   logic [W-1:0]  gen_mem_ff [rsme_pkg::GENERAL_COUNT];
   logic          gen_vld_ff [rsme_pkg::GENERAL_COUNT];
   logic [W-1:0]  gen_rdata_ff;
   logic          gen_rvld_ff;
   logic [W-1:0]  stk_mem_ff [rsme_pkg::STACK_DEPTH];
   logic [W-1:0]  stk_rdata_ff;

   // Control from the sequencer.
   logic                         ins_ld, va_ld, vb_ld, prod_ld;
   logic [rsme_pkg::GEN_AW-1:0]  gen_raddr;
   logic                         gen_we;
   logic [rsme_pkg::GEN_AW-1:0]  gen_waddr;
   logic                         spec_we;
   logic [rsme_pkg::SPEC_AW-1:0] spec_waddr;
   logic [W-1:0]                 spec_wdata;
   logic                         spec_div_we;
   logic                         stk_we, stk_re;
   logic [rsme_pkg::STACK_AW-1:0] stk_waddr, stk_raddr;
   logic                         div_start, div_done;
   logic [W-1:0]                 div_quo, div_rem;
   logic                         out_push;
   rsme_pkg::rsp_type            out_data;
   logic [W-1:0]                 operand_val;
   rsme_pkg::operand_type        cur_opnd;

   // Result queue.
   rsme_pkg::rsp_type  oq_ff [2];
   logic               oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [1:0]         oq_cnt_ff, oq_cnt_in;
   logic               oq_pop;

   rsme_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (va_ff),
      .divisor   (vb_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Operand value; a general register was read in the previous cycle.
   always_comb begin
      cur_opnd = (state_ff == rsme_pkg::SEQ_OPA) ? ins_ff.a : ins_ff.b;
      case (cur_opnd.kind)
         rsme_pkg::KIND_GEN:
            operand_val = (cur_opnd.gen_ok && gen_rvld_ff) ? gen_rdata_ff : '0;
         rsme_pkg::KIND_SPEC:
            operand_val = cur_opnd.spec_ok ?
                          spec_ff[rsme_pkg::SPEC_AW'(cur_opnd.index)] : '0;
         default:
            operand_val = cur_opnd.imm;
      endcase
   end

   // Sequencer: next state and control.
   always_comb begin
      state_in    = state_ff;
      item_pop    = 1'b0;
      ins_ld      = 1'b0;
      va_ld       = 1'b0;
      vb_ld       = 1'b0;
      prod_ld     = 1'b0;
      gen_raddr   = '0;
      gen_we      = 1'b0;
      gen_waddr   = rsme_pkg::GEN_AW'(ins_ff.a.index);
      spec_we     = 1'b0;
      spec_waddr  = rsme_pkg::SPEC_AW'(rsme_pkg::SPEC_SUM);
      spec_wdata  = vb_ff;
      spec_div_we = 1'b0;
      stk_we      = 1'b0;
      stk_re      = 1'b0;
      stk_waddr   = depth_ff[rsme_pkg::STACK_AW-1:0];
      stk_raddr   = rsme_pkg::STACK_AW'(depth_ff - 1'b1);
      depth_in    = depth_ff;
      div_start   = 1'b0;
      out_push    = 1'b0;
      out_data.status      = rsme_pkg::STAT_OK;
      out_data.print_valid = 1'b0;
      out_data.print_value = '0;
      case (state_ff)
         rsme_pkg::SEQ_IDLE: begin
            // One instruction is in flight at a time, so a free queue slot
            // at the start is enough for its result.
            if (item_valid && oq_cnt_ff != 2'd2) begin
               item_pop = 1'b1;
               ins_ld   = 1'b1;
               if (item.a.gen_ok) begin
                  gen_raddr = rsme_pkg::GEN_AW'(item.a.index);
               end
               state_in = rsme_pkg::SEQ_OPA;
            end
         end
         rsme_pkg::SEQ_OPA: begin
            va_ld = 1'b1;
            if (ins_ff.b.gen_ok) begin
               gen_raddr = rsme_pkg::GEN_AW'(ins_ff.b.index);
            end
            state_in = rsme_pkg::SEQ_OPB;
         end
         rsme_pkg::SEQ_OPB: begin
            vb_ld    = 1'b1;
            state_in = rsme_pkg::SEQ_EXEC;
         end
         rsme_pkg::SEQ_EXEC: begin
            state_in = rsme_pkg::SEQ_IDLE;
            case (ins_ff.op)
               rsme_pkg::OP_PUSH: begin
                  out_push = 1'b1;
                  if (32'(depth_ff) >= rsme_pkg::STACK_DEPTH) begin
                     out_data.status = rsme_pkg::STAT_FULL;
                  end else begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + 1'b1;
                  end
               end
               rsme_pkg::OP_POP, rsme_pkg::OP_PRINT: begin
                  if (depth_ff == '0) begin
                     out_push        = 1'b1;
                     out_data.status = rsme_pkg::STAT_EMPTY;
                  end else begin
                     stk_re   = 1'b1;
                     depth_in = depth_ff - 1'b1;
                     state_in = rsme_pkg::SEQ_POPW;
                  end
               end
               rsme_pkg::OP_MOV: begin
                  out_push = 1'b1;
                  if (ins_ff.a.kind == rsme_pkg::KIND_GEN && ins_ff.a.gen_ok) begin
                     gen_we = 1'b1;
                  end else if (ins_ff.a.kind == rsme_pkg::KIND_SPEC &&
                               ins_ff.a.spec_ok) begin
                     spec_we    = 1'b1;
                     spec_waddr = rsme_pkg::SPEC_AW'(ins_ff.a.index);
                  end else begin
                     out_data.status = rsme_pkg::STAT_BADDEST;
                  end
               end
               rsme_pkg::OP_ADD: begin
                  out_push   = 1'b1;
                  spec_we    = 1'b1;
                  spec_wdata = va_ff + vb_ff;
               end
               rsme_pkg::OP_SUB: begin
                  out_push   = 1'b1;
                  spec_we    = 1'b1;
                  spec_wdata = va_ff - vb_ff;
               end
               rsme_pkg::OP_MUL: begin
                  prod_ld  = 1'b1;
                  state_in = rsme_pkg::SEQ_MULW;
               end
               default: begin
                  if (vb_ff == '0) begin
                     out_push        = 1'b1;
                     out_data.status = rsme_pkg::STAT_DIVZERO;
                  end else begin
                     div_start = 1'b1;
                     state_in  = rsme_pkg::SEQ_DIVW;
                  end
               end
            endcase
         end
         rsme_pkg::SEQ_POPW: begin
            out_push = 1'b1;
            state_in = rsme_pkg::SEQ_IDLE;
            if (ins_ff.op == rsme_pkg::OP_POP) begin
               spec_we    = 1'b1;
               spec_waddr = rsme_pkg::SPEC_AW'(rsme_pkg::SPEC_POP);
               spec_wdata = stk_rdata_ff;
            end else begin
               out_data.print_valid = 1'b1;
               out_data.print_value = stk_rdata_ff;
            end
         end
         rsme_pkg::SEQ_MULW: begin
            out_push   = 1'b1;
            spec_we    = 1'b1;
            spec_wdata = prod_ff;
            state_in   = rsme_pkg::SEQ_IDLE;
         end
         rsme_pkg::SEQ_DIVW: begin
            if (div_done) begin
               out_push    = 1'b1;
               spec_div_we = 1'b1;
               state_in    = rsme_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = rsme_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsme_pkg::SEQ_IDLE;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
      end
   end

   // Instruction, operand and product registers.
   always_ff @(posedge clock) begin
      if (ins_ld) begin
         ins_ff <= item;
      end
      if (va_ld) begin
         va_ff <= operand_val;
      end
      if (vb_ld) begin
         vb_ff <= operand_val;
      end
      if (prod_ld) begin
         prod_ff <= va_ff * vb_ff;
      end
   end

   // Special registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rsme_pkg::SPECIAL_COUNT; i++) begin
            spec_ff[i] <= '0;
         end
      end else if (spec_div_we) begin
         spec_ff[rsme_pkg::SPEC_QUO] <= div_quo;
         spec_ff[rsme_pkg::SPEC_REM] <= div_rem;
      end else if (spec_we) begin
         spec_ff[spec_waddr] <= spec_wdata;
      end
   end

   // General register file: one write and one registered read a cycle.
   // A valid bit per entry makes unwritten entries read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rsme_pkg::GENERAL_COUNT; i++) begin
            gen_vld_ff[i] <= 1'b0;
         end
      end else if (gen_we) begin
         gen_vld_ff[gen_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem_ff[gen_waddr] <= vb_ff;
      end
      gen_rdata_ff <= gen_mem_ff[gen_raddr];
      gen_rvld_ff  <= gen_vld_ff[gen_raddr];
   end

   // Value stack memory.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem_ff[stk_waddr] <= va_ff;
      end
      if (stk_re) begin
         stk_rdata_ff <= stk_mem_ff[stk_raddr];
      end
   end

   // Result queue.
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_data  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      oq_wr_in  = out_push ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_pop ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + 2'(out_push) - 2'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         oq_ff[oq_wr_ff] <= out_data;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Testbench of the register stack machine executor: random and directed instruction items.
// A scoreboard class predicts each result from its own copy of the machine state.
// Depends on rsme_pkg and register_stack_machine_executor.
`timescale 1ns / 100ps

module testbench;

   localparam int STALL_MAX = 11;

   // Expected result of one instruction item.
   typedef struct {
      logic [2:0]                      status;
      logic                            print_valid;
      logic [rsme_pkg::DATA_WIDTH-1:0] print_value;
   } outcome_type;

   int error_count = 0;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Machine model and the queue of outcomes it predicts.
   class machine_scoreboard;
      logic [rsme_pkg::DATA_WIDTH-1:0] spec_model [rsme_pkg::SPECIAL_COUNT];
      logic [rsme_pkg::DATA_WIDTH-1:0] gen_model [rsme_pkg::GENERAL_COUNT];
      logic [rsme_pkg::DATA_WIDTH-1:0] value_stack [rsme_pkg::STACK_DEPTH];
      int depth;
      outcome_type pending [$];
      int print_count;
      int fault_count;

      function new();
         foreach (spec_model[i]) spec_model[i] = '0;
         foreach (gen_model[i]) gen_model[i] = '0;
         depth = 0;
         print_count = 0;
         fault_count = 0;
      endfunction

      function logic [rsme_pkg::DATA_WIDTH-1:0] operand(logic [1:0] kind, logic [4:0] idx,
                                                        logic [30:0] imm);
         if (kind == rsme_pkg::KIND_GEN)
            return (idx < rsme_pkg::GENERAL_COUNT) ? gen_model[idx] : '0;
         if (kind == rsme_pkg::KIND_SPEC)
            return (idx < rsme_pkg::SPECIAL_COUNT) ? spec_model[idx] : '0;
         return {1'b0, imm};
      endfunction

      // Notes an accepted instruction item and predicts its outcome.
      function void note_item(logic [2:0] op, logic [1:0] ak, logic [4:0] ai,
                              logic [30:0] aimm, logic [1:0] bk, logic [4:0] bi,
                              logic [30:0] bimm);
         outcome_type res;
         logic [rsme_pkg::DATA_WIDTH-1:0] va, vb, ma, mb, q, r;
         va = operand(ak, ai, aimm);
         vb = operand(bk, bi, bimm);
         res.status = rsme_pkg::STAT_OK;
         res.print_valid = 1'b0;
         res.print_value = '0;
         case (op)
            rsme_pkg::OP_PUSH: begin
               if (depth >= rsme_pkg::STACK_DEPTH) res.status = rsme_pkg::STAT_FULL;
               else begin
                  value_stack[depth] = va;
                  depth++;
               end
            end
            rsme_pkg::OP_POP, rsme_pkg::OP_PRINT: begin
               if (depth == 0) res.status = rsme_pkg::STAT_EMPTY;
               else begin
                  depth--;
                  if (op == rsme_pkg::OP_POP)
                     spec_model[rsme_pkg::SPEC_POP] = value_stack[depth];
                  else begin
                     res.print_valid = 1'b1;
                     res.print_value = value_stack[depth];
                  end
               end
            end
            rsme_pkg::OP_MOV: begin
               if (ak == rsme_pkg::KIND_GEN && ai < rsme_pkg::GENERAL_COUNT)
                  gen_model[ai] = vb;
               else if (ak == rsme_pkg::KIND_SPEC && ai < rsme_pkg::SPECIAL_COUNT)
                  spec_model[ai] = vb;
               else res.status = rsme_pkg::STAT_BADDEST;
            end
            rsme_pkg::OP_ADD: spec_model[rsme_pkg::SPEC_SUM] = va + vb;
            rsme_pkg::OP_SUB: spec_model[rsme_pkg::SPEC_SUM] = va - vb;
            rsme_pkg::OP_MUL: spec_model[rsme_pkg::SPEC_SUM] = va * vb;
            default: begin
               if (vb == 0) res.status = rsme_pkg::STAT_DIVZERO;
               else begin
                  // Divide magnitudes, then restore the signs.
                  ma = va[rsme_pkg::DATA_WIDTH-1] ? -va : va;
                  mb = vb[rsme_pkg::DATA_WIDTH-1] ? -vb : vb;
                  q = ma / mb;
                  r = ma % mb;
                  if (va[rsme_pkg::DATA_WIDTH-1] != vb[rsme_pkg::DATA_WIDTH-1]) q = -q;
                  if (va[rsme_pkg::DATA_WIDTH-1]) r = -r;
                  spec_model[rsme_pkg::SPEC_QUO] = q;
                  spec_model[rsme_pkg::SPEC_REM] = r;
               end
            end
         endcase
         if (res.print_valid) print_count++;
         if (res.status != rsme_pkg::STAT_OK) fault_count++;
         pending.push_back(res);
      endfunction

      // Checks one accepted result item against the oldest outcome.
      task check_result(logic [2:0] status, logic pv,
                        logic [rsme_pkg::DATA_WIDTH-1:0] value);
         outcome_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", status, 0);
         end else begin
            want = pending.pop_front();
            if (status !== want.status) report_mismatch("status", status, want.status);
            if (pv !== want.print_valid)
               report_mismatch("print_valid", pv, want.print_valid);
            if (value !== want.print_value)
               report_mismatch("print_value", value, want.print_value);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [2:0] req_op = '0;
   logic [1:0] req_a_kind = '0;
   logic [rsme_pkg::INDEX_WIDTH-1:0] req_a_index = '0;
   logic [rsme_pkg::IMM_WIDTH-1:0] req_a_imm = '0;
   logic [1:0] req_b_kind = '0;
   logic [rsme_pkg::INDEX_WIDTH-1:0] req_b_index = '0;
   logic [rsme_pkg::IMM_WIDTH-1:0] req_b_imm = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [2:0] rsp_status;
   logic rsp_print_valid;
   logic [rsme_pkg::DATA_WIDTH-1:0] rsp_print_value;

   machine_scoreboard board = new();
   bit quiet = 1'b0;
   int sent = 0;

   register_stack_machine_executor DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Sends one instruction item and waits for its acceptance.
   task automatic send_item(logic [2:0] op, logic [1:0] ak, logic [4:0] ai,
                            logic [30:0] aimm, logic [1:0] bk, logic [4:0] bi,
                            logic [30:0] bimm);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         gap = $urandom_range(1, STALL_MAX);
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_a_kind <= ak;
      req_a_index <= ai;
      req_a_imm <= aimm;
      req_b_kind <= bk;
      req_b_index <= bi;
      req_b_imm <= bimm;
      do @(posedge clock); while (req_full);
      board.note_item(op, ak, ai, aimm, bk, bi, bimm);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [30:0] rand_imm();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(0, 20));
         default: return 31'($urandom);
      endcase
   endfunction

   // Random instruction; kind three and indexes past the files appear too.
   task automatic send_random();
      logic [2:0] op;
      logic [1:0] ak, bk;
      logic [4:0] ai, bi;
      op = 3'($urandom);
      // Lean toward push so that the stack holds values to pop and print.
      if (op != rsme_pkg::OP_PUSH && board.depth < rsme_pkg::STACK_DEPTH - 4 &&
          $urandom_range(0, 3) == 0) op = rsme_pkg::OP_PUSH;
      ak = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      bk = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      ai = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 19));
      bi = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 19));
      if (ak == rsme_pkg::KIND_SPEC && $urandom_range(0, 1)) ai = 5'($urandom_range(0, 4));
      if (bk == rsme_pkg::KIND_SPEC && $urandom_range(0, 1)) bi = 5'($urandom_range(0, 4));
      send_item(op, ak, ai, rand_imm(), bk, bi, rand_imm());
   endtask

   // Result side: accepts results with random stalls.
   initial begin
      int gap;
      @(negedge clock);
      while (!reset) @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            gap = $urandom_range(1, STALL_MAX);
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty) board.check_result(rsp_status, rsp_print_valid, rsp_print_value);
         @(negedge clock);
      end
   end

   // Main stimulus: directed cases, then random instructions.
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Empty stack on pop and print.
      send_item(rsme_pkg::OP_POP, rsme_pkg::KIND_IMM, 0, 0, rsme_pkg::KIND_IMM, 0, 0);
      send_item(rsme_pkg::OP_PRINT, rsme_pkg::KIND_IMM, 0, 0, rsme_pkg::KIND_IMM, 0, 0);
      // Load extreme values into registers.
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_GEN, 19, 0, rsme_pkg::KIND_IMM, 0,
                31'h7FFF_FFFF);
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_SPEC, 4, 0, rsme_pkg::KIND_IMM, 0,
                31'h7FFF_FFFF);
      send_item(rsme_pkg::OP_ADD, rsme_pkg::KIND_SPEC, 4, 0, rsme_pkg::KIND_IMM, 0, 1);
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_GEN, 0, 0, rsme_pkg::KIND_SPEC, 0, 0);
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_GEN, 1, 0, rsme_pkg::KIND_IMM, 0, 0);
      send_item(rsme_pkg::OP_SUB, rsme_pkg::KIND_GEN, 1, 0, rsme_pkg::KIND_IMM, 0, 1);
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_GEN, 2, 0, rsme_pkg::KIND_SPEC, 0, 0);
      // Most negative over minus one, a divide by zero, minus one over three, and a square.
      send_item(rsme_pkg::OP_DIV, rsme_pkg::KIND_GEN, 0, 0, rsme_pkg::KIND_GEN, 2, 0);
      send_item(rsme_pkg::OP_DIV, rsme_pkg::KIND_IMM, 0, 7, rsme_pkg::KIND_GEN, 1, 0);
      send_item(rsme_pkg::OP_DIV, rsme_pkg::KIND_GEN, 2, 0, rsme_pkg::KIND_IMM, 0, 3);
      send_item(rsme_pkg::OP_MUL, rsme_pkg::KIND_GEN, 19, 0, rsme_pkg::KIND_GEN, 19, 0);
      // Bad destinations: immediate, kind three, indexes out of range; bad add operands.
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_IMM, 0, 5, rsme_pkg::KIND_IMM, 0, 1);
      send_item(rsme_pkg::OP_MOV, 2'd3, 0, 5, rsme_pkg::KIND_IMM, 0, 1);
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_GEN, 20, 0, rsme_pkg::KIND_IMM, 0, 1);
      send_item(rsme_pkg::OP_MOV, rsme_pkg::KIND_SPEC, 5, 0, rsme_pkg::KIND_IMM, 0, 1);
      send_item(rsme_pkg::OP_ADD, rsme_pkg::KIND_GEN, 31, 0, 2'd3, 31, 31'h5555_5555);
      // Fill the stack to overflow, then drain it.
      repeat (rsme_pkg::STACK_DEPTH + 1)
         send_item(rsme_pkg::OP_PUSH, rsme_pkg::KIND_IMM, 0, rand_imm(),
                   rsme_pkg::KIND_IMM, 0, 0);
      send_item(rsme_pkg::OP_POP, rsme_pkg::KIND_IMM, 0, 0, rsme_pkg::KIND_IMM, 0, 0);
      repeat (rsme_pkg::STACK_DEPTH)
         send_item(rsme_pkg::OP_PRINT, rsme_pkg::KIND_IMM, 0, 0, rsme_pkg::KIND_IMM, 0, 0);
      send_item(rsme_pkg::OP_PUSH, rsme_pkg::KIND_SPEC, 3, 0, rsme_pkg::KIND_IMM, 0, 0);
      send_item(rsme_pkg::OP_PRINT, rsme_pkg::KIND_IMM, 0, 0, rsme_pkg::KIND_IMM, 0, 0);
      // Random instructions; the last stretch has no idling.
      repeat (1700) begin
         if (sent > 1750) quiet = 1'b1;
         send_random();
      end
      req_push <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      $display("Ran %0d instruction items: %0d prints, %0d faulted instructions.",
               sent, board.print_count, board.fault_count);
      if (error_count == 0 && board.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
